>>> rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and fixed field widths for the byte ring deque.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_POP_BACK   = 2'd1,
    KIND_PUSH_FRONT = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } kind_e;

endpackage

>>> rtl/byte_ring_deque_top.sv
// ----------------------------------------------------------------------------
// byte_ring_deque_top
// Byte deque in a circular byte-wide store, moved one byte per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o): kind, length (clamped to
//   MAX_BURST) and up to eight packed push bytes. One request is worked at a
//   time; in_stall_o is high from acceptance until the request is finished.
//   Result channel (out_valid_o / out_stall_i): bytes moved, popped bytes
//   (byte i at bits 8i, unused bytes zero) and the fill level afterwards.
//   Configuration channel (cfg_valid_i / cfg_ready_o): writes the capacity
//   in use (0 is taken as 1, above DEPTH as DEPTH) and empties the deque;
//   taken only while no request is in work.
// Timing: after acceptance a request passes a setup step, MAX_BURST + 1 byte
//   steps through the single store port incl. read latency, and a result
//   step, at which its result is registered. The next request can be taken
//   in the cycle after that, so requests are worked strictly one at a time.
//   The result register lets the next request start while a result waits.
// Reset: pointers and fill level go to zero, capacity to DEPTH; the store
//   itself is not cleared (only written slots are ever read back).
// Stall: a held result blocks only the result cycle of the following
//   request; the payload stays stable until it is taken.
// ----------------------------------------------------------------------------
module byte_ring_deque_top #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BURST = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [brd_pkg::KIND_W-1:0]  kind_i,
  input  logic [brd_pkg::LEN_W-1:0]   request_length_i,
  input  logic [brd_pkg::DATA_W-1:0]  payload_in_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [brd_pkg::LEN_W-1:0]   bytes_moved_o,
  output logic [brd_pkg::DATA_W-1:0]  payload_out_o,
  output logic [brd_pkg::FILL_W-1:0]  fill_level_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brd_pkg::CAP_W-1:0]   cfg_capacity_in_use_i
);

  // index width, and count width able to hold DEPTH (at least the port width)
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = ($clog2(DEPTH + 1) > brd_pkg::CAP_W) ?
                                 $clog2(DEPTH + 1) : brd_pkg::CAP_W;
  localparam int unsigned CW1  = CW + 1;
  localparam int unsigned SRW  = MAX_BURST * brd_pkg::BYTE_W;
  localparam int unsigned LW   = brd_pkg::LEN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e          state_q;
  brd_pkg::kind_e  kind_q;
  logic [LW-1:0]   len_q;
  logic [LW-1:0]   move_q;
  logic [LW-1:0]   cnt_q;
  logic [SRW-1:0]  sr_q;
  logic [AW-1:0]   addr_q;
  logic [AW-1:0]   head_q;
  logic [AW-1:0]   tail_q;
  logic [CW-1:0]   fill_q;
  logic [CW-1:0]   cap_q;
  logic            rd_vld_q;
  logic [7:0]      rd_q;
  logic            out_valid_q;
  logic            out_valid_d;
  logic [LW-1:0]   moved_q;
  logic [brd_pkg::DATA_W-1:0] pay_out_q;
  logic [brd_pkg::FILL_W-1:0] fill_out_q;

  logic [7:0]      mem [DEPTH];

  // setup-cycle arithmetic
  logic [CW-1:0]   free_w;
  logic [CW-1:0]   len_w;
  logic [LW-1:0]   take_w;
  logic [LW-1:0]   keep_w;
  logic            fits_w;
  logic [LW-1:0]   move_w;
  logic [AW-1:0]   base_w;
  logic            back_w;
  logic [CW1-1:0]  sub_w;
  logic [AW-1:0]   start_w;
  logic [CW-1:0]   cfg_w;
  logic [CW-1:0]   cap_d;
  // byte step
  logic            is_push_w;
  logic            active_w;
  logic            wr_en_w;
  logic            rd_en_w;
  logic [AW-1:0]   addr_d;
  logic [7:0]      top_byte_w;
  logic            out_free_w;

  always_comb begin
    free_w = cap_q - fill_q;
    len_w  = CW'(len_q);
    take_w = (fill_q < len_w) ? fill_q[LW-1:0] : len_q;
    keep_w = (free_w < len_w) ? free_w[LW-1:0] : len_q;
    fits_w = (CW1'(fill_q) + CW1'(len_q)) <= CW1'(cap_q);
    move_w = '0;
    base_w = tail_q;
    back_w = 1'b0;
    unique case (kind_q)
      brd_pkg::KIND_PUSH_BACK: begin
        move_w = keep_w;
        base_w = tail_q;
      end
      brd_pkg::KIND_POP_BACK: begin
        move_w = take_w;
        base_w = tail_q;
        back_w = 1'b1;
      end
      brd_pkg::KIND_PUSH_FRONT: begin
        move_w = fits_w ? len_q : '0;
        base_w = head_q;
        back_w = 1'b1;
      end
      brd_pkg::KIND_POP_FRONT: begin
        move_w = take_w;
        base_w = head_q;
      end
      default: begin
        move_w = '0;
      end
    endcase
    // step back by the move count, wrapping at the capacity in use
    sub_w = (CW1'(base_w) >= CW1'(move_w)) ? (CW1'(base_w) - CW1'(move_w)) :
            (CW1'(base_w) + CW1'(cap_q) - CW1'(move_w));
    start_w = back_w ? AW'(sub_w) : base_w;
  end

  always_comb begin
    cfg_w = CW'(cfg_capacity_in_use_i);
    if (cfg_w == '0) begin
      cap_d = CW'(1);
    end else if (cfg_w > CW'(DEPTH)) begin
      cap_d = CW'(DEPTH);
    end else begin
      cap_d = cfg_w;
    end
  end

  assign is_push_w  = (kind_q == brd_pkg::KIND_PUSH_BACK) ||
                      (kind_q == brd_pkg::KIND_PUSH_FRONT);
  assign active_w   = (state_q == ST_RUN) && (cnt_q < move_q);
  assign wr_en_w    = active_w && is_push_w;
  assign rd_en_w    = active_w && !is_push_w;
  assign addr_d     = ((CW'(addr_q) + CW'(1)) == cap_q) ? '0 : (addr_q + AW'(1));
  assign top_byte_w = rd_vld_q ? rd_q : 8'h00;
  assign out_free_w = !out_valid_q || !out_stall_i;
  // result register: loaded when a request finishes, held while stalled
  assign out_valid_d = ((state_q == ST_FINISH) && out_free_w) ? 1'b1 :
                       (out_valid_q && out_stall_i);

  // byte store: one port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_w) begin
      mem[addr_q] <= sr_q[7:0];
    end
    if (rd_en_w) begin
      rd_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= brd_pkg::KIND_PUSH_BACK;
      len_q       <= '0;
      move_q      <= '0;
      cnt_q       <= '0;
      sr_q        <= '0;
      addr_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      cap_q       <= CW'(DEPTH);
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      moved_q     <= '0;
      pay_out_q   <= '0;
      fill_out_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            cap_q  <= cap_d;
            head_q <= '0;
            tail_q <= '0;
            fill_q <= '0;
          end
          if (in_valid_i) begin
            kind_q  <= brd_pkg::kind_e'(kind_i);
            len_q   <= (request_length_i > LW'(MAX_BURST)) ? LW'(MAX_BURST) :
                       request_length_i;
            sr_q    <= payload_in_i[SRW-1:0];
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          move_q   <= move_w;
          addr_q   <= start_w;
          cnt_q    <= '0;
          rd_vld_q <= 1'b0;
          fill_q   <= is_push_w ? (fill_q + CW'(move_w)) : (fill_q - CW'(move_w));
          if (kind_q == brd_pkg::KIND_POP_BACK) begin
            tail_q <= start_w;
          end
          if (kind_q == brd_pkg::KIND_PUSH_FRONT) begin
            head_q <= start_w;
          end
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (active_w) begin
            addr_q <= addr_d;
          end
          rd_vld_q <= rd_en_w;
          // push: low byte goes out, zeros fill; pop: read data enters on top
          if (is_push_w) begin
            if (cnt_q < LW'(MAX_BURST)) begin
              sr_q <= sr_q >> brd_pkg::BYTE_W;
            end
          end else if (cnt_q != '0) begin
            sr_q <= (sr_q >> brd_pkg::BYTE_W) |
                    (SRW'(top_byte_w) << (SRW - brd_pkg::BYTE_W));
          end
          cnt_q <= cnt_q + LW'(1);
          if (cnt_q == LW'(MAX_BURST)) begin
            if (kind_q == brd_pkg::KIND_PUSH_BACK) begin
              tail_q <= addr_q;
            end
            if (kind_q == brd_pkg::KIND_POP_FRONT) begin
              head_q <= addr_q;
            end
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free_w) begin
            moved_q     <= move_q;
            pay_out_q   <= brd_pkg::DATA_W'(sr_q);
            fill_out_q  <= fill_q[brd_pkg::FILL_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign bytes_moved_o = moved_q;
  assign payload_out_o = pay_out_q;
  assign fill_level_o  = fill_out_q;

  // fill never exceeds the capacity in use
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("fill count above capacity");

  // ring pointers stay inside the capacity in use
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(head_q) < cap_q) && (CW'(tail_q) < cap_q))
    else $error("ring pointer out of range");

  // a finished result never reports more than one burst
  a_moved_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bytes_moved_o <= LW'(MAX_BURST)))
    else $error("bytes moved above burst limit");

  // the byte step counter never passes MAX_BURST during the byte walk
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= LW'(MAX_BURST)))
    else $error("byte step counter overran");

endmodule
